>>> rtl/cftp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cftp_pkg: shared types and constants of the fingertip peak picker
// Field widths, register indexes, reset values and the control records
// passed between the distance pipeline, the peak tracker and the tip chain.
// ----------------------------------------------------------------------------
package cftp_pkg;

	localparam int FIELD_W      = 12;
	localparam int LIMIT_W      = 8;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 12;
	localparam int IN_TDATA_W   = 24;
	localparam int OUT_TDATA_W  = 24;

	localparam int DEF_MAX_TIPS   = 8;
	localparam int DEF_COORD_BITS = 12;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SEPARATION = 2'd3;

	localparam logic [LIMIT_W-1:0] HOLD_LIMIT_RST     = 8'd40;
	localparam logic [FIELD_W-1:0] MIN_SEPARATION_RST = 12'd20;

	typedef struct packed {
		logic valid;
		logic close;
	} chain_ctl_t;

	typedef struct packed {
		logic done;
		logic launch;
	} peak_res_t;

endpackage

>>> rtl/cftp_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cftp_dist: squared distance pipeline
// Three stages: absolute differences, squares, sum. The point and its
// contour start flag travel alongside.
// ----------------------------------------------------------------------------
module cftp_dist
	import cftp_pkg::*;
#(
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic [COORD_BITS-1:0]   px,
	input  logic [COORD_BITS-1:0]   py,
	input  logic                    start,
	input  logic [COORD_BITS-1:0]   cx,
	input  logic [COORD_BITS-1:0]   cy,
	output logic                    valid_s3,
	output logic [2*COORD_BITS:0]   dist_s3,
	output logic [COORD_BITS-1:0]   px_s3,
	output logic [COORD_BITS-1:0]   py_s3,
	output logic                    start_s3
);

	localparam int CB = COORD_BITS;

	logic          valid_s1, valid_s2;
	logic [CB-1:0] dx_s1, dy_s1, px_s1, py_s1, px_s2, py_s2;
	logic          start_s1, start_s2;
	logic [2*CB-1:0] sqx_s2, sqy_s2;
	logic [CB-1:0] dx, dy;

	assign dx = (px > cx) ? px - cx : cx - px;
	assign dy = (py > cy) ? py - cy : cy - py;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1    <= dx;
		dy_s1    <= dy;
		px_s1    <= px;
		py_s1    <= py;
		start_s1 <= start;
		sqx_s2   <= dx_s1 * dx_s1;
		sqy_s2   <= dy_s1 * dy_s1;
		px_s2    <= px_s1;
		py_s2    <= py_s1;
		start_s2 <= start_s1;
		dist_s3  <= (2*CB+1)'(sqx_s2) + (2*CB+1)'(sqy_s2);
		px_s3    <= px_s2;
		py_s3    <= py_s2;
		start_s3 <= start_s2;
	end

endmodule

>>> rtl/cftp_peak.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cftp_peak: running maximum and hold counter
// Keeps the largest distance seen and its point, counts points below the
// maximum and takes a peak once the count passes the hold limit.
// ----------------------------------------------------------------------------
module cftp_peak
	import cftp_pkg::*;
#(
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid,
	input  logic                    start,
	input  logic [2*COORD_BITS:0]   sq_dist,
	input  logic [COORD_BITS-1:0]   px,
	input  logic [COORD_BITS-1:0]   py,
	input  logic [COORD_BITS-1:0]   cy,
	input  logic [LIMIT_W-1:0]      hold_limit,
	output logic [COORD_BITS-1:0]   peak_x,
	output logic [COORD_BITS-1:0]   peak_y,
	output peak_res_t               res
);

	localparam int CB = COORD_BITS;

	logic [2*CB:0]      dist_q, pd, nd;
	logic [LIMIT_W-1:0] hold_q, hc, nh;
	logic [CB-1:0]      x_q, y_q, ox, oy, nx, ny;
	logic               take;

	always_comb begin
		pd   = start ? '0 : dist_q;
		hc   = start ? '0 : hold_q;
		ox   = start ? '0 : x_q;
		oy   = start ? '0 : y_q;
		nd   = pd;
		nh   = hc;
		nx   = ox;
		ny   = oy;
		take = 1'b0;
		priority if (sq_dist > pd) begin
			nd = sq_dist;
			nx = px;
			ny = py;
		end else if (sq_dist != pd) begin
			if (hc < hold_limit) begin
				nh = hc + 1'b1;
			end else begin
				nh   = '0;
				nd   = '0;
				take = 1'b1;
			end
		end
		res.launch = valid && take && (ny <= cy);
		res.done   = valid && !res.launch;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= '0;
			hold_q <= '0;
			x_q    <= '0;
			y_q    <= '0;
		end else if (valid) begin
			dist_q <= nd;
			hold_q <= nh;
			x_q    <= nx;
			y_q    <= ny;
		end
	end

	assign peak_x = x_q;
	assign peak_y = y_q;

endmodule

>>> rtl/cftp_tip_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cftp_tip_cell: one entry of the tip chain
// Holds one accepted tip column. A candidate flag passes through each cycle
// the chain moves; it is marked close if this entry is in use and too near.
// ----------------------------------------------------------------------------
module cftp_tip_cell
	import cftp_pkg::*;
#(
	parameter int COORD_BITS = DEF_COORD_BITS,
	parameter int TOTAL_W    = 4,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  chain_ctl_t            ctl_in,
	input  logic [COORD_BITS-1:0] cand_x,
	input  logic [FIELD_W-1:0]    min_sep,
	input  logic [TOTAL_W-1:0]    total,
	input  logic                  commit,
	output chain_ctl_t            ctl_out
);

	localparam int CB = COORD_BITS;
	localparam int CW = CB + FIELD_W;
	localparam logic [TOTAL_W-1:0] MY_IDX = TOTAL_W'(IDX);

	logic [CB-1:0] column_q, diff;
	logic          in_use, near;

	assign in_use = MY_IDX < total;
	assign diff   = (cand_x > column_q) ? cand_x - column_q : column_q - cand_x;
	assign near   = in_use && (CW'(diff) < CW'(min_sep));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (adv) begin
			ctl_out.valid <= ctl_in.valid;
			ctl_out.close <= ctl_in.valid && (ctl_in.close || near);
		end
	end

	always_ff @(posedge clk) begin
		if (commit && total == MY_IDX) begin
			column_q <= cand_x;
		end
	end

endmodule

>>> rtl/contour_fingertip_peak_picker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contour_fingertip_peak_picker_top: fingertip peak picker on a contour
// Tracks the farthest contour point from the palm centre and turns held
// peaks into fingertips, checked against earlier tips along a cell chain.
//
// Channel  Direction  Handshake                  Payload
// s_axis   in         s_axis_tvalid/tready       point_x, point_y; tuser start
// m_axis   out        m_axis_tvalid/tready       tip_x, tip_y
// cfg      in         cfg_we                     cfg_index, cfg_data
//
// A point holds the input off while it passes the three-stage distance
// pipeline and the peak update. A point that takes a peak at or above the
// centre row also waits while its candidate walks the tip chain, one cell a
// cycle unless the chain end is held. A result waiting in the output register
// holds the chain end; the next point is taken once the candidate has left
// the chain end, its tip moving to the output register if accepted.
// Reset clears the peak state, the tip count and the registers to defaults.
// ----------------------------------------------------------------------------
module contour_fingertip_peak_picker_top
	import cftp_pkg::*;
#(
	parameter int MAX_TIPS   = DEF_MAX_TIPS,
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // point_x [11:0], point_y [23:12]
	input  logic [0:0]             s_axis_tuser,  // contour_start [0]
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // tip_x [11:0], tip_y [23:12]
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CB      = COORD_BITS;
	localparam int TOTAL_W = $clog2(MAX_TIPS + 1);
	localparam logic [TOTAL_W-1:0] TIPS_FULL = TOTAL_W'(MAX_TIPS);

	logic [FIELD_W-1:0] center_x_q, center_y_q, min_sep_q;
	logic [LIMIT_W-1:0] hold_limit_q;

	logic               busy_q, accept;
	logic [CB-1:0]      px, py, cx, cy;
	logic               valid_s3, start_s3;
	logic [2*CB:0]      dist_s3;
	logic [CB-1:0]      px_s3, py_s3, peak_x, peak_y;
	peak_res_t          pk_res;

	logic               launch_q;
	chain_ctl_t         ctl [0:MAX_TIPS];
	logic [TOTAL_W-1:0] total_q;
	logic               out_free, fin, commit;

	logic               out_valid_q;
	logic [FIELD_W-1:0] tip_x_q, tip_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q   <= '0;
			center_y_q   <= '0;
			hold_limit_q <= HOLD_LIMIT_RST;
			min_sep_q    <= MIN_SEPARATION_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CENTER_X:       center_x_q   <= cfg_data;
				REG_CENTER_Y:       center_y_q   <= cfg_data;
				REG_HOLD_LIMIT:     hold_limit_q <= cfg_data[LIMIT_W-1:0];
				REG_MIN_SEPARATION: min_sep_q    <= cfg_data;
				default:            ;
			endcase
		end
	end

	assign s_axis_tready = !busy_q;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign px = CB'(s_axis_tdata[FIELD_W-1:0]);
	assign py = CB'(s_axis_tdata[2*FIELD_W-1:FIELD_W]);
	assign cx = CB'(center_x_q);
	assign cy = CB'(center_y_q);

	cftp_dist #(
		.COORD_BITS(CB)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.px       (px),
		.py       (py),
		.start    (s_axis_tuser[0]),
		.cx       (cx),
		.cy       (cy),
		.valid_s3 (valid_s3),
		.dist_s3  (dist_s3),
		.px_s3    (px_s3),
		.py_s3    (py_s3),
		.start_s3 (start_s3)
	);

	cftp_peak #(
		.COORD_BITS(CB)
	) u_peak (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (valid_s3),
		.start      (start_s3),
		.sq_dist    (dist_s3),
		.px         (px_s3),
		.py         (py_s3),
		.cy         (cy),
		.hold_limit (hold_limit_q),
		.peak_x     (peak_x),
		.peak_y     (peak_y),
		.res        (pk_res)
	);

	assign out_free = !out_valid_q || m_axis_tready;
	assign fin      = ctl[MAX_TIPS].valid && out_free;
	assign commit   = fin && !ctl[MAX_TIPS].close && (total_q < TIPS_FULL);

	assign ctl[0] = '{valid: launch_q, close: 1'b0};

	for (genvar i = 0; i < MAX_TIPS; i++) begin : g_cell
		cftp_tip_cell #(
			.COORD_BITS (CB),
			.TOTAL_W    (TOTAL_W),
			.IDX        (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (!ctl[MAX_TIPS].valid || out_free),
			.ctl_in  (ctl[i]),
			.cand_x  (peak_x),
			.min_sep (min_sep_q),
			.total   (total_q),
			.commit  (commit),
			.ctl_out (ctl[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			launch_q <= 1'b0;
			total_q  <= '0;
		end else begin
			launch_q <= pk_res.launch;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (pk_res.done || fin) begin
				busy_q <= 1'b0;
			end
			if (valid_s3 && start_s3) begin
				total_q <= '0;
			end else if (commit) begin
				total_q <= total_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			tip_x_q <= FIELD_W'(peak_x);
			tip_y_q <= FIELD_W'(peak_y);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {tip_y_q, tip_x_q};

endmodule

>>> rtl/cftp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cftp_checker: port-level checks for the fingertip peak picker
// Watches the stream ports for the block's timing and output holding.
// ----------------------------------------------------------------------------
module cftp_checker
	import cftp_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// While a point is in the distance pipeline, the input port takes no new point.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
	else $error("point taken while the previous one is still in the pipeline");

	// A new result only appears at the end of a point's processing.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
	else $error("result appeared while the block was idle");

	// A result is never issued without a preceding point transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready, 2))
	else $error("result appeared too soon after the block went idle");

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
	else $error("stalled result changed");

endmodule

bind contour_fingertip_peak_picker_top cftp_checker u_cftp_checker (.*);

>>> bench/tb_contour_fingertip_peak_picker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_contour_fingertip_peak_picker_top: self-checking bench for the peak picker
// Streams contour points into the block, predicts every fingertip from its own
// model of the peak tracker and tip store, and compares each output transfer
// field by field. Directed cases cover the corner behaviour. Random contours
// also run under several register settings and three idling patterns, with a
// long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_contour_fingertip_peak_picker_top;
	import cftp_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int MAX_TIPS     = DEF_MAX_TIPS;
	localparam int TIP_IDX_W    = $clog2(MAX_TIPS);
	localparam int DRAIN_CYCLES = 2 * (MAX_TIPS + 5);
	localparam int STALL_LIMIT  = 4000;
	localparam int MAX_REPORTS  = 10;
	localparam int HOLDOFF_LEN  = 200;

	typedef struct packed {
		logic [FIELD_W-1:0] y;
		logic [FIELD_W-1:0] x;
	} tip_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic [0:0]             s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	logic [FIELD_W-1:0] ctr_x;
	logic [FIELD_W-1:0] ctr_y;
	logic [LIMIT_W-1:0] hold_lim;
	logic [FIELD_W-1:0] min_sep;

	logic [25:0]        peak_dist;
	logic [LIMIT_W-1:0] hold_cnt;
	logic [FIELD_W-1:0] peak_x;
	logic [FIELD_W-1:0] peak_y;
	logic [FIELD_W-1:0] tip_cols [MAX_TIPS];
	logic [3:0]         tip_cnt;

	tip_t pending_tips [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int holdoff_req   = 0;
	int holdoff_left  = 0;
	int error_count   = 0;
	int stall_cycles  = 0;

	contour_fingertip_peak_picker_top #(
		.MAX_TIPS   (MAX_TIPS),
		.COORD_BITS (DEF_COORD_BITS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [FIELD_W-1:0] col_gap(input logic [FIELD_W-1:0] a,
			input logic [FIELD_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic int clamp_coord(input int v);
		if (v < 0) begin
			return 0;
		end
		if (v > 4095) begin
			return 4095;
		end
		return v;
	endfunction

	function automatic void clear_tracker();
		peak_dist = '0;
		hold_cnt  = '0;
		peak_x    = '0;
		peak_y    = '0;
		tip_cnt   = '0;
		foreach (tip_cols[k]) begin
			tip_cols[k] = '0;
		end
	endfunction

	function automatic void predict_point(input logic [FIELD_W-1:0] px,
			input logic [FIELD_W-1:0] py, input logic start);
		logic [25:0] ddx;
		logic [25:0] ddy;
		logic [25:0] sq_dist;
		tip_t        tip;
		if (start) begin
			clear_tracker();
		end
		ddx     = 26'(col_gap(px, ctr_x));
		ddy     = 26'(col_gap(py, ctr_y));
		sq_dist = ddx * ddx + ddy * ddy;
		if (sq_dist > peak_dist) begin
			peak_dist = sq_dist;
			peak_x    = px;
			peak_y    = py;
		end
		if (sq_dist == peak_dist) begin
			return;
		end
		if (hold_cnt < hold_lim) begin
			hold_cnt = hold_cnt + 1'b1;
			return;
		end
		hold_cnt  = '0;
		peak_dist = '0;
		if (peak_y > ctr_y) begin
			return;
		end
		for (int k = 0; k < int'(tip_cnt) && k < MAX_TIPS; k++) begin
			if (col_gap(peak_x, tip_cols[k]) < min_sep) begin
				return;
			end
		end
		if (int'(tip_cnt) >= MAX_TIPS) begin
			return;
		end
		tip_cols[tip_cnt[TIP_IDX_W-1:0]] = peak_x;
		tip_cnt      = tip_cnt + 1'b1;
		tip.x        = peak_x;
		tip.y        = peak_y;
		pending_tips = {pending_tips, tip};
	endfunction

	task automatic send_point(input int px, input int py, input logic start);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {FIELD_W'(py), FIELD_W'(px)};
		s_axis_tuser  <= start;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		predict_point(FIELD_W'(px), FIELD_W'(py), start);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_tips.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CENTER_X: begin
				ctr_x = value;
			end
			REG_CENTER_Y: begin
				ctr_y = value;
			end
			REG_HOLD_LIMIT: begin
				hold_lim = value[LIMIT_W-1:0];
			end
			REG_MIN_SEPARATION: begin
				min_sep = value;
			end
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	task automatic set_registers(input int cx, input int cy, input int hl, input int sep);
		wait_idle();
		write_register(REG_CENTER_X, CFG_DATA_W'(cx));
		write_register(REG_CENTER_Y, CFG_DATA_W'(cy));
		write_register(REG_HOLD_LIMIT, CFG_DATA_W'(hl & 8'hFF));
		write_register(REG_MIN_SEPARATION, CFG_DATA_W'(sep));
	endtask

	// Contours are random walks with occasional jumps anywhere on the
	// frame and a few stray start flags in the middle of a contour.
	task automatic run_contours(input int total, input int min_len, input int max_len);
		int sent;
		int len;
		int x;
		int y;
		sent = 0;
		while (sent < total) begin
			len = $urandom_range(min_len, max_len);
			x   = $urandom_range(0, 4095);
			y   = $urandom_range(0, 4095);
			for (int i = 0; i < len && sent < total; i++) begin
				if ($urandom_range(0, 99) < 10) begin
					send_point($urandom_range(0, 4095), $urandom_range(0, 4095),
						$urandom_range(0, 99) < 3);
				end else begin
					x = clamp_coord(x + int'($urandom_range(0, 48)) - 24);
					y = clamp_coord(y + int'($urandom_range(0, 48)) - 24);
					send_point(x, y, (i == 0) || ($urandom_range(0, 99) < 2));
				end
				sent++;
			end
		end
	endtask

	task automatic test_reset_defaults();
		run_contours(60, 8, 60);
	endtask

	task automatic test_directed_peaks();
		set_registers(2048, 4095, 1, 0);
		send_point(0, 0, 1'b1);
		send_point(0, 0, 1'b0);
		send_point(2048, 4095, 1'b0);
		send_point(2048, 4095, 1'b0);
		send_point(4095, 0, 1'b0);
		send_point(4095, 0, 1'b0);
		send_point(2048, 4095, 1'b0);
		send_point(2048, 4095, 1'b0);
		send_point(4095, 4095, 1'b1);
	endtask

	task automatic test_directed_store_full();
		set_registers(0, 4095, 0, 0);
		for (int k = 1; k <= MAX_TIPS + 1; k++) begin
			send_point(k * 400, 0, k == 1);
			send_point(0, 4095, 1'b0);
		end
	endtask

	task automatic test_directed_rejects();
		set_registers(0, 0, 0, 4095);
		send_point(10, 5, 1'b1);
		send_point(0, 0, 1'b0);
		send_point(10, 0, 1'b0);
		send_point(0, 0, 1'b0);
		send_point(4095, 0, 1'b0);
		send_point(0, 0, 1'b0);
	endtask

	task automatic test_random_settings(input int phases, input int per_phase);
		for (int p = 0; p < phases; p++) begin
			set_registers($urandom_range(0, 4095), $urandom_range(1500, 4095),
				$urandom_range(1, 12), $urandom_range(0, 150));
			run_contours(per_phase, 8, 160);
		end
	endtask

	task automatic test_receiver_holdoff();
		int saved_pct;
		saved_pct = send_idle_pct;
		set_registers(0, 4095, 0, 0);
		send_idle_pct = 0;
		holdoff_req   = HOLDOFF_LEN;
		for (int i = 0; i < 40; i += 2) begin
			send_point($urandom_range(1, 4095), $urandom_range(0, 4094), (i % 16) == 0);
			send_point(0, 4095, 1'b0);
		end
		wait_idle();
		send_idle_pct = saved_pct;
	endtask

	task automatic test_register_extremes();
		set_registers(0, 4095, 0, 0);
		run_contours(100, 8, 80);
		set_registers(4095, 0, 3, 4095);
		run_contours(100, 8, 80);
		set_registers(4095, 4095, 255, 50);
		run_contours(400, 300, 400);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (holdoff_req != 0) begin
				holdoff_left = holdoff_req;
				holdoff_req  = 0;
			end
			if (holdoff_left > 0) begin
				holdoff_left  = holdoff_left - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		tip_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_tips.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS) begin
					$display("Unexpected tip transfer: x %0d y %0d",
						m_axis_tdata[FIELD_W-1:0], m_axis_tdata[2*FIELD_W-1:FIELD_W]);
				end
			end else begin
				want = pending_tips.pop_front();
				if (m_axis_tdata[FIELD_W-1:0] !== want.x ||
						m_axis_tdata[2*FIELD_W-1:FIELD_W] !== want.y) begin
					error_count++;
					if (error_count <= MAX_REPORTS) begin
						$display("Tip mismatch: expected x %0d y %0d, got x %0d y %0d",
							want.x, want.y, m_axis_tdata[FIELD_W-1:0],
							m_axis_tdata[2*FIELD_W-1:FIELD_W]);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles = stall_cycles + 1;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("CHECK FAILED");
					$finish;
				end
			end
		end
	end

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		cfg_we        <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		ctr_x    = '0;
		ctr_y    = '0;
		hold_lim = HOLD_LIMIT_RST;
		min_sep  = MIN_SEPARATION_RST;
		clear_tracker();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 22;
		recv_idle_pct = 82;
		test_reset_defaults();
		test_directed_peaks();
		test_directed_store_full();
		test_directed_rejects();
		test_random_settings(4, 100);

		send_idle_pct = 82;
		recv_idle_pct = 22;
		test_receiver_holdoff();
		test_register_extremes();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_settings(3, 100);

		wait_idle();
		if (error_count == 0 && pending_tips.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
